// File: src/atf_pkg.sv
// ----------------------------------------------------------------------------
// atf_pkg: shared types and constants of the tilt filter
// cordic arctangent table in 1/65536 degree, kinds and status codes
// ----------------------------------------------------------------------------
package atf_pkg;

  localparam int unsigned AtanDepth = 24;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_LEVEL   = 2'd1,
    KIND_LOAD    = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_BAD_MAG = 2'd1,
    ST_READ_FAIL = 2'd2,
    ST_OFFSETS = 2'd3
  } status_e;

  localparam int unsigned RegGain = 0;
  localparam int unsigned RegMagMin = 1;
  localparam int unsigned RegMagMax = 2;

  function automatic logic [21:0] atan_entry(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0: v = 22'd2949120;   5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;    5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;    5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;     5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;     5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;     5'd11: v = 22'd1833;
      5'd12: v = 22'd917;      5'd13: v = 22'd458;
      5'd14: v = 22'd229;      5'd15: v = 22'd115;
      5'd16: v = 22'd57;       5'd17: v = 22'd29;
      5'd18: v = 22'd14;       5'd19: v = 22'd7;
      5'd20: v = 22'd4;        5'd21: v = 22'd2;
      5'd22: v = 22'd1;        default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/accel_tilt_filter_top.sv
// ----------------------------------------------------------------------------
// accel_tilt_filter_top: accelerometer tilt with first-order smoothing
// a measure item runs the squares, the magnitude checks, the 16-step square
// root, two passes of the shared cordic unit and both filter updates; a level
// item skips the filter updates, and load-offsets and failed reads go straight
// to the output; one item at a time, the next is taken only once the result
// has left; reset clears offsets, filter state and the registers to their
// defaults; an output register lets the result wait for tready
// ----------------------------------------------------------------------------
module accel_tilt_filter_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: accel_x, accel_y, accel_z, gyro_rate_z, sample_ok, pitch_offset_in,
  // roll_offset_in, zero fill
  input  logic [103:0] s_axis_tdata,
  // tuser: kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: pitch_angle, roll_angle, yaw_rate, zero fill
  output logic [55:0]  m_axis_tdata,
  // tuser: status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_MAG_LO, S_MAG_HI, S_SQRT, S_CP_START, S_CP_WAIT,
    S_CR_START, S_CR_WAIT, S_FILT_P, S_FILT_R, S_OUT
  } state_e;

  state_e state_q;
  logic [15:0] gain_q;
  logic [14:0] mmin_q, mmax_q;
  logic signed [15:0] poff_q, roff_q;
  logic signed [31:0] fp_q, fr_q;
  logic started_q;

  // captured item
  logic [1:0] kind_q;
  logic signed [15:0] ax_q, ay_q, az_q, gz_q, pin_q, rin_q;
  logic ok_q;

  // shared multiplier operands and result
  logic signed [33:0] mul_a, mul_b;
  logic signed [49:0] mul_p;
  logic [32:0] yz2_q, mag2_q;
  logic [31:0] sq_rem_q;
  logic [16:0] root_q;
  logic [4:0]  cnt_q;
  logic signed [15:0] rp_q, rr_q;

  logic cd_start, cd_done;
  logic signed [17:0] cd_y, cd_x;
  logic signed [15:0] cd_angle;

  logic out_valid_q;
  logic signed [16:0] out_p_q, out_r_q;
  logic signed [15:0] out_yaw_q;
  logic [1:0] out_st_q;

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_yaw_q, out_r_q, out_p_q};
  assign m_axis_tuser  = out_st_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd5243;
      mmin_q <= 15'd4096;
      mmax_q <= 15'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        2'(atf_pkg::RegGain):   gain_q <= cfg_data_i;
        2'(atf_pkg::RegMagMin): mmin_q <= cfg_data_i[14:0];
        2'(atf_pkg::RegMagMax): mmax_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // one multiplier shared by squares, magnitude limits and both filter updates
  logic signed [31:0] tgt_p, tgt_r;
  assign tgt_p = (32'(rp_q) - 32'(poff_q)) <<< 12;
  assign tgt_r = (32'(rr_q) - 32'(roff_q)) <<< 12;
  always_comb begin
    mul_a = '0; mul_b = '0;
    unique case (state_q)
      S_SQ_X:   begin mul_a = 34'(ax_q); mul_b = 34'(ax_q); end
      S_SQ_Y:   begin mul_a = 34'(ay_q); mul_b = 34'(ay_q); end
      S_SQ_Z:   begin mul_a = 34'(az_q); mul_b = 34'(az_q); end
      S_MAG_LO: begin mul_a = 34'({1'b0, mmin_q}); mul_b = 34'({1'b0, mmin_q}); end
      S_MAG_HI: begin mul_a = 34'({1'b0, mmax_q}); mul_b = 34'({1'b0, mmax_q}); end
      S_FILT_P: begin mul_a = {17'd0, gain_q, 1'b0} >>> 1; mul_b = 34'(tgt_p) - 34'(fp_q); end
      S_FILT_R: begin mul_a = {17'd0, gain_q, 1'b0} >>> 1; mul_b = 34'(tgt_r) - 34'(fr_q); end
      default: ;
    endcase
    mul_p = 50'(mul_a) * 50'(mul_b);
  end

  // restoring square root, one result bit per cycle
  logic [32:0] trial;
  logic [32:0] rem_sh;
  assign rem_sh = {sq_rem_q[30:0], yz2_q[31:30]} ;
  assign trial  = rem_sh - {14'd0, root_q, 2'b01};

  logic signed [31:0] step_p;
  assign step_p = 32'((mul_p + 50'sd32768) >>> 16);

  function automatic logic signed [16:0] rnd_out(input logic signed [31:0] f);
    logic signed [32:0] t;
    t = (33'(f) + 33'sd2048) >>> 12;
    return t[16:0];
  endfunction

  assign cd_start = (state_q == S_CP_START) || (state_q == S_CR_START);
  assign cd_y = (state_q == S_CP_START) ? -18'(ax_q) : 18'(ay_q);
  assign cd_x = (state_q == S_CP_START) ? 18'({1'b0, root_q}) : 18'(az_q);

  atf_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cd_start), .y_i(cd_y), .x_i(cd_x),
    .done_o(cd_done), .angle_o(cd_angle)
  );

  logic [1:0] st_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      poff_q <= '0; roff_q <= '0;
      fp_q <= '0; fr_q <= '0;
      started_q <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          kind_q <= s_axis_tuser;
          ax_q <= s_axis_tdata[15:0];  ay_q <= s_axis_tdata[31:16];
          az_q <= s_axis_tdata[47:32]; gz_q <= s_axis_tdata[63:48];
          ok_q <= s_axis_tdata[64];
          pin_q <= s_axis_tdata[80:65]; rin_q <= s_axis_tdata[96:81];
          state_q <= S_SQ_Y;
        end
        S_SQ_Y: begin
          if (kind_q == atf_pkg::KIND_LOAD) begin
            poff_q <= pin_q; roff_q <= rin_q;
            out_st_q <= atf_pkg::ST_OFFSETS;
            state_q <= S_OUT;
          end else if (!ok_q) begin
            out_st_q <= atf_pkg::ST_READ_FAIL;
            state_q <= S_OUT;
          end else begin
            yz2_q <= 33'(mul_p);
            state_q <= S_SQ_Z;
          end
        end
        S_SQ_Z: begin yz2_q <= yz2_q + 33'(mul_p); state_q <= S_SQ_X; end
        S_SQ_X: begin mag2_q <= yz2_q + 33'(mul_p); state_q <= S_MAG_LO; end
        S_MAG_LO: begin
          if (kind_q != atf_pkg::KIND_LEVEL && mag2_q < 33'(mul_p)) begin
            out_st_q <= atf_pkg::ST_BAD_MAG; state_q <= S_OUT;
          end else state_q <= S_MAG_HI;
        end
        S_MAG_HI: begin
          if (kind_q != atf_pkg::KIND_LEVEL && mag2_q > 33'(mul_p)) begin
            out_st_q <= atf_pkg::ST_BAD_MAG; state_q <= S_OUT;
          end else begin
            sq_rem_q <= '0; root_q <= '0; cnt_q <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          // two radicand bits per step, 16 steps cover the 32-bit radicand
          if (!trial[32]) begin
            sq_rem_q <= trial[31:0]; root_q <= {root_q[15:0], 1'b1};
          end else begin
            sq_rem_q <= rem_sh[31:0]; root_q <= {root_q[15:0], 1'b0};
          end
          yz2_q <= {yz2_q[30:0], 2'b00};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd15) state_q <= S_CP_START;
        end
        S_CP_START: state_q <= S_CP_WAIT;
        S_CP_WAIT: if (cd_done) begin rp_q <= cd_angle; state_q <= S_CR_START; end
        S_CR_START: state_q <= S_CR_WAIT;
        S_CR_WAIT: if (cd_done) begin
          rr_q <= cd_angle;
          if (kind_q == atf_pkg::KIND_LEVEL) begin
            poff_q <= rp_q; roff_q <= cd_angle;
            fp_q <= '0; fr_q <= '0; started_q <= 1'b0;
            out_st_q <= atf_pkg::ST_OFFSETS;
            state_q <= S_OUT;
          end else state_q <= S_FILT_P;
        end
        S_FILT_P: begin
          if (!started_q) fp_q <= tgt_p;
          else fp_q <= fp_q + step_p;
          state_q <= S_FILT_R;
        end
        S_FILT_R: begin
          if (!started_q) fr_q <= tgt_r;
          else fr_q <= fr_q + step_p;
          started_q <= 1'b1;
          out_st_q <= atf_pkg::ST_UPDATED;
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_p_q <= rnd_out(fp_q);
          out_r_q <= rnd_out(fr_q);
          out_yaw_q <= (out_st_q == atf_pkg::ST_UPDATED) ? gz_q : 16'sd0;
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
  assign st_d = out_st_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE && !out_valid_q) else $error("ready while busy");
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT) else $error("stray result");
  a_yaw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_d != atf_pkg::ST_UPDATED |-> out_yaw_q == 16'sd0)
    else $error("yaw on held item");

endmodule

// File: src/atf_cordic.sv
// ----------------------------------------------------------------------------
// atf_cordic: iterative cordic vectoring unit
// one micro-rotation per cycle, result in 1/128 degree, clamped to +-180
// ----------------------------------------------------------------------------
module atf_cordic #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [17:0] y_i,
  input  logic signed [17:0] x_i,
  output logic               done_o,
  output logic signed [15:0] angle_o
);

  localparam int unsigned StepW = $clog2(CordicSteps + 1);
  localparam int unsigned Ax = 34;  // |x| grows to about 1.65 * 2^17 * 2^14 * 1.42

  logic signed [Ax-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [27:0]   z_q, z_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic signed [Ax-1:0] xs, ys;
  logic signed [27:0]   zr;
  logic signed [27:0]   ta;

  assign xs = Ax'(x_i) <<< 14;
  assign ys = Ax'(y_i) <<< 14;
  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign ta = 28'(atf_pkg::atan_entry(5'(step_q)));
  assign zr = (z_q + 28'sd256) >>> 9;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; step_d = step_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      if (x_i == '0 && y_i == '0) begin
        x_d = '0; y_d = '0; z_d = '0; busy_d = 1'b0; done_d = 1'b1;
      end else if (x_i < 0) begin
        if (y_i >= 0) begin
          x_d = ys; y_d = -xs; z_d = 28'sd5898240;
        end else begin
          x_d = -ys; y_d = xs; z_d = -28'sd5898240;
        end
      end else begin
        x_d = xs; y_d = ys; z_d = '0;
      end
    end else if (busy_q) begin
      if (step_q == StepW'(CordicSteps) || step_q >= StepW'(atf_pkg::AtanDepth)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (y_q >= 0) begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + ta;
        end else begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - ta;
        end
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  always_comb begin
    if (zr > 28'sd23040) angle_o = 16'sd23040;
    else if (zr < -28'sd23040) angle_o = -16'sd23040;
    else angle_o = 16'(zr);
  end

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= StepW'(CordicSteps)) else $error("cordic step overrun");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> busy_q || done_q) else $error("cordic lost work");

endmodule
